// ===== rtl/core/i2cbm_pkg.sv =====
// Shared types and constants for the I2C byte master core.
`timescale 1ns / 1ps
`default_nettype none

package i2cbm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned DelayW      = 16;
  localparam int unsigned BitCntW     = 4;
  localparam int unsigned CfgAddrW    = 3;

  // Reset values of the timing registers
  localparam logic [DelayW-1:0] LongDelayRst  = 16'd9;
  localparam logic [DelayW-1:0] ShortDelayRst = 16'd0;

  // Command codes
  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop  = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;
  localparam logic [1:0] KindRead  = 2'd3;

  // Register index (byte address bit 2)
  localparam logic RegLongDelay  = 1'b0;
  localparam logic RegShortDelay = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_S0   = 5'd1,
    PH_S1   = 5'd2,
    PH_S2   = 5'd3,
    PH_P0   = 5'd4,
    PH_P1   = 5'd5,
    PH_P2   = 5'd6,
    PH_W0   = 5'd7,
    PH_W1   = 5'd8,
    PH_A0   = 5'd9,
    PH_A1   = 5'd10,
    PH_A2   = 5'd11,
    PH_WEND = 5'd12,
    PH_R0   = 5'd13,
    PH_R1   = 5'd14,
    PH_R2   = 5'd15,
    PH_R3   = 5'd16,
    PH_R4   = 5'd17,
    PH_R5   = 5'd18
  } phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       send_nak;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       bus_error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_byte_master_core.sv =====
// I2C byte master: per-tick bus sequencer with APB timing registers.
//
// Each input beat is one tick of bus time and yields exactly one result beat
// carrying the SCL/SDA levels, busy/done status, last read byte and the
// error flag, which each start reloads. The core takes one beat per clock
// cycle while the result side does not stall; a beat passes an input
// register, one level of sequencer logic and a result register.
// The sequencer state advances only when a beat moves from the input register
// into the result register. Start, stop, write-byte and read-byte commands
// are taken only while the sequencer is idle; long phases (start, stop,
// acknowledge) are timed by the long delay and data-bit half phases by the
// short delay. Registers: 0x0 long delay (reset 9), 0x4 short delay
// (reset 0), 16 bits each. No clock stretching, no arbitration.
`timescale 1ns / 1ps
`default_nettype none

module i2c_byte_master_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // command beats
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire i2cbm_pkg::cmd_t                  in_data_i,
  // result beats
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output i2cbm_pkg::res_t                       out_data_o,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [i2cbm_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  import i2cbm_pkg::*;

  // Configuration registers
  logic [DelayW-1:0] long_dly_q, short_dly_q;
  logic              cfg_we;

  // Pipeline registers
  logic in_vld_q, out_vld_q;
  cmd_t in_q;
  res_t res_q, res_d;
  logic out_free, advance;

  // Sequencer state
  phase_e            phase_q, phase_d, op_phase;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [BitCntW-1:0] bit_q, bit_d, bit_base;
  logic [7:0]        shift_q, shift_d, shift_base;
  logic              err_q, err_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              nak_q, nak_d, nak_base;
  logic [7:0]        rx_q, rx_d;
  logic              run_op, is_idle, done;
  logic              bits_full;

  // APB access: always ready, decode on address bit 2
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == RegShortDelay) begin
      prdata = {16'd0, short_dly_q};
    end else begin
      prdata = {16'd0, long_dly_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_dly_q  <= LongDelayRst;
      short_dly_q <= ShortDelayRst;
    end else if (cfg_we) begin
      if (paddr[2] == RegLongDelay) begin
        long_dly_q <= pwdata[DelayW-1:0];
      end else begin
        short_dly_q <= pwdata[DelayW-1:0];
      end
    end
  end

  // Handshake: result register frees when empty or taken
  assign out_free    = !out_vld_q || !out_stall_i;
  assign advance     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Pick the operation to run this tick
  assign is_idle   = (phase_q == PH_IDLE);
  assign run_op    = is_idle ? in_q.cmd_valid : (delay_q == '0);
  assign bit_base  = is_idle ? '0 : bit_q;
  assign bits_full = (bit_q >= BitCntW'(BitsPerByte));

  always_comb begin
    op_phase   = phase_q;
    shift_base = shift_q;
    nak_base   = nak_q;
    if (is_idle) begin
      case (in_q.kind)
        KindStart: op_phase = PH_S0;
        KindStop:  op_phase = PH_P0;
        KindWrite: begin
          op_phase   = PH_W0;
          shift_base = in_q.tx_byte;
        end
        default: begin
          op_phase   = PH_R0;
          shift_base = '0;
          nak_base   = in_q.send_nak;
        end
      endcase
    end
  end

  // Next phase and delay
  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    if (!run_op) begin
      if (!is_idle) begin
        delay_d = delay_q - DelayW'(1);
      end
    end else begin
      delay_d = '0;
      case (op_phase)
        PH_S0: begin phase_d = PH_S1; delay_d = long_dly_q; end
        PH_S1: begin phase_d = PH_S2; delay_d = long_dly_q; end
        PH_P0: begin phase_d = PH_P1; delay_d = long_dly_q; end
        PH_P1: begin phase_d = PH_P2; delay_d = long_dly_q; end
        PH_W0: begin phase_d = PH_W1; delay_d = short_dly_q; end
        PH_W1: begin
          phase_d = bits_full ? PH_A0 : PH_W0;
          delay_d = short_dly_q;
        end
        PH_A0: begin phase_d = PH_A1;   delay_d = long_dly_q; end
        PH_A1: begin phase_d = PH_A2;   delay_d = long_dly_q; end
        PH_A2: begin phase_d = PH_WEND; delay_d = long_dly_q; end
        PH_R0: begin phase_d = PH_R1;   delay_d = long_dly_q; end
        PH_R1: begin phase_d = PH_R2;   delay_d = short_dly_q; end
        PH_R2: begin
          phase_d = bits_full ? PH_R3 : PH_R1;
          delay_d = short_dly_q;
        end
        PH_R3: begin phase_d = PH_R4; delay_d = long_dly_q; end
        PH_R4: begin phase_d = PH_R5; delay_d = long_dly_q; end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Line levels, shifter, flags and result
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    err_d   = err_q;
    nak_d   = nak_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (run_op) begin
      shift_d = shift_base;
      bit_d   = bit_base;
      nak_d   = nak_base;
      case (op_phase)
        PH_S0: begin sda_d = 1'b1; scl_d = 1'b1; end
        PH_S1: begin
          err_d = !in_q.sda_in;
          sda_d = 1'b0;
        end
        PH_S2: begin scl_d = 1'b0; done = 1'b1; end
        PH_P0: sda_d = 1'b0;
        PH_P1: scl_d = 1'b1;
        PH_P2: begin sda_d = 1'b1; done = 1'b1; end
        PH_W0: begin
          scl_d   = 1'b0;
          sda_d   = shift_base[7];
          shift_d = {shift_base[6:0], 1'b0};
          bit_d   = bit_base + BitCntW'(1);
        end
        PH_W1: scl_d = 1'b1;
        PH_A0: begin scl_d = 1'b0; sda_d = 1'b1; end
        PH_A1: scl_d = 1'b1;
        PH_A2: begin
          err_d = err_q | in_q.sda_in;
          scl_d = 1'b0;
        end
        PH_WEND: done = 1'b1;
        PH_R0: sda_d = 1'b1;
        PH_R1: begin
          scl_d   = 1'b1;
          shift_d = {shift_base[6:0], in_q.sda_in};
          bit_d   = bit_base + BitCntW'(1);
        end
        PH_R2: scl_d = 1'b0;
        PH_R3: sda_d = nak_base;
        PH_R4: scl_d = 1'b1;
        PH_R5: begin
          scl_d = 1'b0;
          rx_d  = shift_base;
          done  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d.scl_out   = scl_d;
    res_d.sda_out   = sda_d;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.done_res  = done;
    res_d.rx_byte   = rx_d;
    res_d.bus_error = err_d;
  end

  // Advance sequencer state once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      delay_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      err_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      nak_q   <= 1'b0;
      rx_q    <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      err_q   <= err_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      nak_q   <= nak_d;
      rx_q    <= rx_d;
    end
  end

  // Checks
  a_idle_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (delay_q == '0))
    else $error("idle sequencer holds a pending delay");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= BitCntW'(BitsPerByte))
    else $error("bit count past byte length");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("done reported while still busy");

  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with free result register");

  a_state_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q) && $stable(delay_q))
    else $error("sequencer moved without a beat");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the I2C byte master core: stimulus, prediction, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import i2cbm_pkg::*;

  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned LongHoldAt = 600;
  localparam int unsigned LongHoldLen = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  i2c_byte_master_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Bus-tick beats waiting to go out, and predicted line states waiting to come back
  cmd_t tick_q[$];
  res_t line_state_q[$];

  // Sequencer mirror
  phase_e      seq_ph;
  logic [3:0]  seq_bits;
  logic [7:0]  seq_shift;
  logic [15:0] seq_delay;
  logic        seq_err;
  logic        seq_scl;
  logic        seq_sda;
  logic        seq_nak;
  logic [7:0]  seq_rx;
  logic [15:0] long_ticks;
  logic [15:0] short_ticks;

  bit          idle_en = 1'b1;
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_checked = 0;
  int unsigned settings_n = 0;
  int unsigned cmd_taken[4];
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          long_hold_done = 1'b0;
  res_t        want_res;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Handshake idling: mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void seq_goto(input phase_e nxt, input logic [15:0] ticks);
    seq_ph = nxt;
    seq_delay = ticks;
  endfunction

  // Run the bus operation of the current phase; return 1 when the command completes
  function automatic bit seq_op(input logic sda);
    bit fin;
    fin = 1'b0;
    case (seq_ph)
      PH_S0: begin seq_sda = 1'b1; seq_scl = 1'b1; seq_goto(PH_S1, long_ticks); end
      PH_S1: begin seq_err = ~sda; seq_sda = 1'b0; seq_goto(PH_S2, long_ticks); end
      PH_S2: begin seq_scl = 1'b0; seq_goto(PH_IDLE, '0); fin = 1'b1; end
      PH_P0: begin seq_sda = 1'b0; seq_goto(PH_P1, long_ticks); end
      PH_P1: begin seq_scl = 1'b1; seq_goto(PH_P2, long_ticks); end
      PH_P2: begin seq_sda = 1'b1; seq_goto(PH_IDLE, '0); fin = 1'b1; end
      PH_W0: begin
        seq_scl = 1'b0;
        seq_sda = seq_shift[7];
        seq_shift = {seq_shift[6:0], 1'b0};
        seq_bits = seq_bits + 4'd1;
        seq_goto(PH_W1, short_ticks);
      end
      PH_W1: begin
        seq_scl = 1'b1;
        seq_goto((seq_bits >= BitsPerByte) ? PH_A0 : PH_W0, short_ticks);
      end
      PH_A0: begin seq_scl = 1'b0; seq_sda = 1'b1; seq_goto(PH_A1, long_ticks); end
      PH_A1: begin seq_scl = 1'b1; seq_goto(PH_A2, long_ticks); end
      PH_A2: begin
        if (sda) seq_err = 1'b1;
        seq_scl = 1'b0;
        seq_goto(PH_WEND, long_ticks);
      end
      PH_WEND: begin seq_goto(PH_IDLE, '0); fin = 1'b1; end
      PH_R0: begin seq_sda = 1'b1; seq_goto(PH_R1, long_ticks); end
      PH_R1: begin
        seq_scl = 1'b1;
        seq_shift = {seq_shift[6:0], sda};
        seq_bits = seq_bits + 4'd1;
        seq_goto(PH_R2, short_ticks);
      end
      PH_R2: begin
        seq_scl = 1'b0;
        seq_goto((seq_bits >= BitsPerByte) ? PH_R3 : PH_R1, short_ticks);
      end
      PH_R3: begin seq_sda = seq_nak; seq_goto(PH_R4, long_ticks); end
      PH_R4: begin seq_scl = 1'b1; seq_goto(PH_R5, long_ticks); end
      PH_R5: begin
        seq_scl = 1'b0;
        seq_rx = seq_shift;
        seq_goto(PH_IDLE, '0);
        fin = 1'b1;
      end
      default: seq_goto(PH_IDLE, '0);
    endcase
    return fin;
  endfunction

  // Advance the mirror by one bus tick and queue the line state it produces
  task automatic predict_tick(input cmd_t c);
    bit fin;
    res_t r;
    fin = 1'b0;
    if (seq_ph == PH_IDLE) begin
      if (c.cmd_valid) begin
        seq_bits = '0;
        seq_delay = '0;
        cmd_taken[c.kind]++;
        case (c.kind)
          KindStart: seq_ph = PH_S0;
          KindStop:  seq_ph = PH_P0;
          KindWrite: begin seq_shift = c.tx_byte; seq_ph = PH_W0; end
          KindRead:  begin seq_nak = c.send_nak; seq_shift = '0; seq_ph = PH_R0; end
          default: ;
        endcase
        fin = seq_op(c.sda_in);
      end
    end else if (seq_delay != '0) begin
      seq_delay = seq_delay - 16'd1;
    end else begin
      fin = seq_op(c.sda_in);
    end
    r.scl_out   = seq_scl;
    r.sda_out   = seq_sda;
    r.busy_res  = (seq_ph != PH_IDLE);
    r.done_res  = fin;
    r.rx_byte   = seq_rx;
    r.bus_error = seq_err;
    line_state_q.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Command driver: one beat per bus tick, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tick(in_data);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= tick_q.pop_front();
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (line_state_q.size() == 0) begin
          $error("result beat arrived with no bus tick pending");
          errors++;
        end else begin
          want_res = line_state_q.pop_front();
          check_field("scl_out", want_res.scl_out, out_data.scl_out);
          check_field("sda_out", want_res.sda_out, out_data.sda_out);
          check_field("busy_res", want_res.busy_res, out_data.busy_res);
          check_field("done_res", want_res.done_res, out_data.done_res);
          check_field("rx_byte", want_res.rx_byte, out_data.rx_byte);
          check_field("bus_error", want_res.bus_error, out_data.bus_error);
        end
        beats_checked++;
      end
      // Hold off once for a long stretch so the core backs up into its input
      if (!long_hold_done && beats_checked >= LongHoldAt) begin
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
        stall_left <= LongHoldLen;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        int unsigned n;
        n = pick_gap();
        out_stall <= (n != 0);
        stall_left <= (n != 0) ? n - 1 : 0;
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("tb_top: no handshake progress for %0d cycles", WatchLimit);
        $display("tb_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_beat(input cmd_t b);
    while (tick_q.size() >= QueueDepth) @(negedge clk_i);
    tick_q.push_back(b);
  endtask

  // Bus ticks with no command offered
  task automatic idle_ticks(input int unsigned n);
    cmd_t b;
    repeat (n) begin
      b.cmd_valid = 1'b0;
      b.kind = 2'($urandom_range(0, 3));
      b.tx_byte = 8'($urandom);
      b.send_nak = 1'($urandom);
      b.sda_in = 1'($urandom);
      push_beat(b);
    end
  endtask

  // Offer one command on an idle tick, then cover its whole span with noise ticks.
  // bus_ok steers the start sample high and the write acknowledge low.
  task automatic send_cmd(input logic [1:0] kind, input logic [7:0] data, input logic nak,
                          input bit bus_ok);
    int unsigned lng, sht, span, k, rel, j;
    cmd_t b;
    lng = long_ticks;
    sht = short_ticks;
    if (kind == KindStart || kind == KindStop) span = 3 + 2 * lng;
    else span = 16 * (1 + sht) + 3 * (1 + lng) + 1;
    for (k = 0; k < span; k++) begin
      b.cmd_valid = (k == 0) ? 1'b1 : ($urandom_range(0, 7) == 0);
      b.kind = (k == 0) ? kind : 2'($urandom_range(0, 3));
      b.tx_byte = (k == 0) ? data : 8'($urandom);
      b.send_nak = (k == 0) ? nak : 1'($urandom);
      b.sda_in = 1'($urandom);
      if (kind == KindStart && k == 1 + lng) b.sda_in = bus_ok;
      if (kind == KindWrite && k == 16 * (1 + sht) + 2 * (1 + lng)) b.sda_in = !bus_ok;
      if (kind == KindRead && k >= 1 + lng) begin
        rel = k - (1 + lng);
        j = rel / (2 * (1 + sht));
        if (rel % (2 * (1 + sht)) == 0 && j < 8) b.sda_in = data[7 - j];
      end
      push_beat(b);
    end
  endtask

  // Wait until every beat has gone out and every prediction has been matched
  task automatic drain_all();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid || line_state_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reprogram both delays with the sequencer at rest
  task automatic set_delays(input logic [15:0] lng, input logic [15:0] sht);
    drain_all();
    while (seq_ph != PH_IDLE) begin
      idle_ticks(32);
      drain_all();
    end
    apb_write({RegLongDelay, 2'b00}, lng);
    long_ticks = lng;
    apb_write({RegShortDelay, 2'b00}, sht);
    short_ticks = sht;
    settings_n++;
  endtask

  // Mostly framed transfers (start, bytes, stop), some stray commands
  task automatic random_batch(input int unsigned count);
    int unsigned sent, n, k;
    logic [1:0] kd;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                 $urandom_range(0, 3) != 0);
        sent++;
      end else begin
        send_cmd(KindStart, 8'($urandom), 1'($urandom), $urandom_range(0, 15) != 0);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          kd = $urandom_range(0, 1) ? KindWrite : KindRead;
          send_cmd(kd, 8'($urandom), (k == n - 1) ? 1'b1 : ($urandom_range(0, 3) == 0),
                   $urandom_range(0, 3) != 0);
        end
        send_cmd(KindStop, 8'($urandom), 1'($urandom), 1'b1);
        sent += n + 2;
      end
      idle_ticks(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3));
    end
  endtask

  initial begin
    seq_ph = PH_IDLE;
    seq_bits = '0;
    seq_shift = '0;
    seq_delay = '0;
    seq_err = 1'b0;
    seq_scl = 1'b1;
    seq_sda = 1'b1;
    seq_nak = 1'b0;
    seq_rx = '0;
    long_ticks = LongDelayRst;
    short_ticks = ShortDelayRst;
    foreach (cmd_taken[i]) cmd_taken[i] = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, ACK and NAK both ways, SDA stuck low at start
    send_cmd(KindStart, 8'h00, 1'b0, 1'b1);
    send_cmd(KindWrite, 8'hFF, 1'b0, 1'b1);
    send_cmd(KindWrite, 8'h00, 1'b0, 1'b0);
    send_cmd(KindWrite, 8'h80, 1'b1, 1'b1);
    send_cmd(KindWrite, 8'h01, 1'b0, 1'b1);
    send_cmd(KindRead, 8'hFF, 1'b0, 1'b1);
    send_cmd(KindRead, 8'h00, 1'b1, 1'b1);
    send_cmd(KindRead, 8'hA5, 1'b0, 1'b1);
    send_cmd(KindRead, 8'h5A, 1'b1, 1'b1);
    send_cmd(KindStop, 8'h00, 1'b0, 1'b1);
    idle_ticks(3);
    send_cmd(KindStart, 8'h00, 1'b0, 1'b0);
    send_cmd(KindStop, 8'h00, 1'b0, 1'b1);
    idle_ticks(2);
    send_cmd(KindStart, 8'h00, 1'b0, 1'b1);
    send_cmd(KindWrite, 8'h3C, 1'b0, 1'b0);
    send_cmd(KindStop, 8'h00, 1'b0, 1'b1);

    // Random traffic over several delay settings, minimum delays first
    set_delays(16'd1, 16'd0);
    random_batch(10);
    set_delays(16'd2, 16'd0);
    random_batch(10);
    set_delays(16'd1, 16'd1);
    random_batch(8);
    idle_en = 1'b0;
    set_delays(16'd3, 16'd2);
    random_batch(4);
    idle_en = 1'b1;
    set_delays(16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)));
    random_batch(4);

    drain_all();
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d ticks in, %0d result beats checked, %0d delay settings",
             beats_in, beats_checked, settings_n);
    $display("tb_top: commands taken: start %0d, stop %0d, write %0d, read %0d",
             cmd_taken[KindStart], cmd_taken[KindStop], cmd_taken[KindWrite],
             cmd_taken[KindRead]);
    if (errors == 0 && line_state_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/i2cbm_pkg.sv
rtl/core/i2c_byte_master_core.sv
test/tb_top.sv
